[rtl/frns_pkg.sv]
`timescale 1ns / 1ps

package frns_pkg;

  // Parameter defaults for the top level.
  localparam int unsigned MAX_NODES_DEF  = 16384;
  localparam int unsigned BLOCK_DEF      = 64;
  localparam int unsigned COORD_BITS_DEF = 24;

  // Fixed field widths of the item ports.
  localparam int unsigned IDX_W   = 14;
  localparam int unsigned CAND_W  = IDX_W + 1;
  localparam int unsigned NCNT_W  = 15;
  localparam int unsigned RAD_W   = 52;
  localparam int unsigned POS_W   = 24;
  localparam int unsigned COORD_W = 24;

  // Result queue depth, a power of two.
  localparam int unsigned FIFO_DEPTH = 8;

  // Register port geometry.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 64;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic {
    REG_RADIUS     = 1'b0,
    REG_NODE_COUNT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0] query_node;
    logic [IDX_W-1:0] neighbor_index;
    logic             found;
    logic [POS_W-1:0] list_position;
    logic             last;
  } result_t;

  // Status of the distance pipeline as seen by the scan controller.
  typedef struct packed {
    logic              sq_busy;
    logic              hit;
    logic [CAND_W-1:0] cand;
  } dist_stat_t;

endpackage

[rtl/frns_coord_mem.sv]
`timescale 1ns / 1ps

module frns_coord_mem #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned DW    = 72
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/frns_dist.sv]
`timescale 1ns / 1ps

module frns_dist
  import frns_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [CAND_W-1:0]       cand_i,
  input  logic [3*COORD_BITS-1:0] ci_i,
  input  logic [3*COORD_BITS-1:0] cj_i,
  input  logic [RAD_W-1:0]        radius_i,
  output dist_stat_t              stat_o
);

  localparam int unsigned SQ_W  = 2 * COORD_BITS + 2;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned CMP_W = (SUM_W > RAD_W) ? SUM_W : RAD_W;

  logic signed [COORD_BITS:0] diff [3];
  logic signed [SQ_W-1:0]     prod [3];
  logic [SQ_W-1:0]            sq_q [3];
  logic                       sq_v_q;
  logic [CAND_W-1:0]          cand_sq_q;
  logic [SUM_W-1:0]           sum;
  logic                       hit_d, hit_q;
  logic [CAND_W-1:0]          cand_hit_q;

  // Differences are exact; one square per axis, registered.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = signed'({ci_i[(a+1)*COORD_BITS-1], ci_i[a*COORD_BITS +: COORD_BITS]})
              - signed'({cj_i[(a+1)*COORD_BITS-1], cj_i[a*COORD_BITS +: COORD_BITS]});
      prod[a] = diff[a] * diff[a];
    end
  end

  // The exact sum never saturates below the radius range, so a plain
  // compare gives the same answer as the saturating one.
  assign sum   = SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
  assign hit_d = sq_v_q && (CMP_W'(sum) < CMP_W'(radius_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      sq_v_q <= valid_i;
      hit_q  <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      sq_q[a] <= $unsigned(prod[a]);
    end
    cand_sq_q  <= cand_i;
    cand_hit_q <= cand_sq_q;
  end

  assign stat_o.sq_busy = sq_v_q;
  assign stat_o.hit     = hit_q;
  assign stat_o.cand    = cand_hit_q;

endmodule

[rtl/frns_res_fifo.sv]
`timescale 1ns / 1ps

module frns_res_fifo
  import frns_pkg::*;
#(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  result_t                    push_data_i,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output result_t                    out_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  result_t       buf_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rd_ptr_q];
  assign full_o      = (cnt_q == CW'(DEPTH));
  assign count_o     = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      unique case ({push_i, pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[rtl/fixed_radius_neighbor_search.sv]
`timescale 1ns / 1ps
// A store item does not hold the input. A query item holds it while the controller fetches
// node i, reads each candidate from the coordinate memory read port, drains the distance
// pipeline and queues the last result. Each neighbor is held until the next one arrives or the scan ends.
// Reset clears the controller, the position counter and the registers (radius_squared 0,
// node_count 16384); the coordinate memory is not cleared and needs no clearing pass.
module fixed_radius_neighbor_search
  import frns_pkg::*;
#(
  parameter int unsigned MAX_NODES  = MAX_NODES_DEF,
  parameter int unsigned BLOCK      = BLOCK_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Input items.
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      opcode_i,
  input  logic [IDX_W-1:0]          node_index_i,
  input  logic signed [COORD_W-1:0] x_coord_i,
  input  logic signed [COORD_W-1:0] y_coord_i,
  input  logic signed [COORD_W-1:0] z_coord_i,
  input  logic [IDX_W-1:0]          block_base_i,
  // Result items.
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [IDX_W-1:0]          query_node_o,
  output logic [IDX_W-1:0]          neighbor_index_o,
  output logic                      found_o,
  output logic [POS_W-1:0]          list_position_o,
  output logic                      last_o,
  // Register port.
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  localparam int unsigned AW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = 3 * COORD_BITS;
  localparam int unsigned KW  = $clog2(BLOCK + 1);
  localparam int unsigned FCW = $clog2(FIFO_DEPTH + 1);

  // The controller fetches node i, issues one candidate read per cycle while the result
  // queue has room, waits for the distance pipeline to empty and queues the closing result.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CATCH,
    S_SCAN,
    S_DRAIN,
    S_FINAL
  } state_e;

  // Configuration registers.
  logic [RAD_W-1:0]  radius_q;
  logic [NCNT_W-1:0] node_count_q;
  logic              cfg_wr;

  // Controller state.
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  qi_q, qi_d;
  logic [CAND_W-1:0] cand_q, cand_d;
  logic [KW-1:0]     k_q, k_d;
  logic [CW-1:0]     ci_q, ci_d;
  result_t           hold_q, hold_d;
  logic              hold_v_q, hold_v_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              v1_q;
  logic [CAND_W-1:0] cand1_q;

  // Datapath glue.
  logic              in_accept;
  logic              store_acc, query_acc;
  logic              qi_in_range, store_in_range;
  logic              cand_skip, scan_done, room, issue, advance;
  logic [1:0]        inflight;
  logic              mem_wr_en, mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [CW-1:0]     mem_wr_data, mem_rd_data;
  logic [COORD_BITS-1:0] x_trunc, y_trunc, z_trunc;
  logic [COORD_BITS+COORD_W-1:0] x_wide, y_wide, z_wide;
  dist_stat_t        dist_st;
  logic              push, fifo_full;
  result_t           push_data, out_data;
  logic [FCW-1:0]    fifo_cnt;

  // ------------------------------------------------------------------
  // Register port. The index is taken from paddr bit 3; each register
  // spans one 64-bit slot.
  // ------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= '0;
      node_count_q <= NCNT_W'(16384);
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3]))
        REG_RADIUS:     radius_q     <= pwdata[RAD_W-1:0];
        REG_NODE_COUNT: node_count_q <= pwdata[NCNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[3]))
      REG_RADIUS:     prdata = APB_DW'(radius_q);
      REG_NODE_COUNT: prdata = APB_DW'(node_count_q);
    endcase
  end

  // ------------------------------------------------------------------
  // Input side. New items are taken only while the controller is idle,
  // so a query never overlaps a store to the coordinate memory.
  // ------------------------------------------------------------------
  assign in_stall_o     = (state_q != S_IDLE);
  assign in_accept      = in_valid_i && !in_stall_o;
  assign store_acc      = in_accept && (opcode_e'(opcode_i) == OP_STORE);
  assign query_acc      = in_accept && (opcode_e'(opcode_i) == OP_QUERY);
  assign qi_in_range    = (32'(node_index_i) < 32'(MAX_NODES));
  assign store_in_range = qi_in_range;

  // Coordinates are kept at COORD_BITS bits; reading them back sign-extends.
  assign x_wide      = {{COORD_BITS{1'b0}}, x_coord_i};
  assign y_wide      = {{COORD_BITS{1'b0}}, y_coord_i};
  assign z_wide      = {{COORD_BITS{1'b0}}, z_coord_i};
  assign x_trunc     = x_wide[COORD_BITS-1:0];
  assign y_trunc     = y_wide[COORD_BITS-1:0];
  assign z_trunc     = z_wide[COORD_BITS-1:0];
  assign mem_wr_data = {z_trunc, y_trunc, x_trunc};
  assign mem_wr_en   = store_acc && store_in_range;

  // ------------------------------------------------------------------
  // Candidate scan. A candidate equal to i, at or past node_count, or
  // outside the memory is skipped without a read. A read is issued only
  // when the result queue can absorb every result still in flight.
  // ------------------------------------------------------------------
  assign cand_skip = (cand_q == CAND_W'(qi_q))
                  || (cand_q >= CAND_W'(node_count_q))
                  || (32'(cand_q) >= 32'(MAX_NODES));
  assign scan_done = (k_q == KW'(BLOCK));
  assign inflight  = 2'(v1_q) + 2'(dist_st.sq_busy) + 2'(dist_st.hit);
  assign room      = (32'(fifo_cnt) + 32'(inflight) + 32'd1) <= 32'(FIFO_DEPTH);
  assign issue     = (state_q == S_SCAN) && !scan_done && !cand_skip && room;
  assign advance   = (state_q == S_SCAN) && !scan_done && (cand_skip || room);

  assign mem_rd_en   = issue || (query_acc && qi_in_range);
  assign mem_rd_addr = (state_q == S_SCAN) ? AW'(cand_q) : AW'(node_index_i);

  frns_coord_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW),
    .DW    (CW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (AW'(node_index_i)),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  frns_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v1_q),
    .cand_i   (cand1_q),
    .ci_i     (ci_q),
    .cj_i     (mem_rd_data),
    .radius_i (radius_q),
    .stat_o   (dist_st)
  );

  // ------------------------------------------------------------------
  // Result ordering. Each neighbor waits in a hold register until either
  // the next neighbor arrives (so it is not the last) or the scan ends
  // (so it is). An empty scan queues a single found=0 result instead.
  // ------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    qi_d      = qi_q;
    cand_d    = cand_q;
    k_d       = k_q;
    ci_d      = ci_q;
    hold_d    = hold_q;
    hold_v_d  = hold_v_q;
    pos_d     = pos_q;
    push      = 1'b0;
    push_data = hold_q;

    if (dist_st.hit) begin
      push                  = hold_v_q;
      push_data             = hold_q;
      hold_d.query_node     = qi_q;
      hold_d.neighbor_index = dist_st.cand[IDX_W-1:0];
      hold_d.found          = 1'b1;
      hold_d.list_position  = pos_q;
      hold_d.last           = 1'b0;
      hold_v_d              = 1'b1;
      if (pos_q != POS_MAX) begin
        pos_d = pos_q + POS_W'(1);
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (query_acc) begin
          qi_d     = node_index_i;
          cand_d   = CAND_W'(block_base_i);
          k_d      = '0;
          hold_v_d = 1'b0;
          state_d  = qi_in_range ? S_CATCH : S_FINAL;
        end
      end
      S_CATCH: begin
        ci_d    = mem_rd_data;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_DRAIN;
        end else if (advance) begin
          cand_d = cand_q + CAND_W'(1);
          k_d    = k_q + KW'(1);
        end
      end
      S_DRAIN: begin
        if (!v1_q && !dist_st.sq_busy && !dist_st.hit) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (!fifo_full) begin
          push     = 1'b1;
          hold_v_d = 1'b0;
          state_d  = S_IDLE;
          if (hold_v_q) begin
            push_data      = hold_q;
            push_data.last = 1'b1;
          end else begin
            push_data.query_node     = qi_q;
            push_data.neighbor_index = '0;
            push_data.found          = 1'b0;
            push_data.list_position  = pos_q;
            push_data.last           = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hold_v_q <= 1'b0;
      pos_q    <= '0;
      v1_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      hold_v_q <= hold_v_d;
      pos_q    <= pos_d;
      v1_q     <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    qi_q    <= qi_d;
    cand_q  <= cand_d;
    k_q     <= k_d;
    ci_q    <= ci_d;
    hold_q  <= hold_d;
    cand1_q <= cand_q;
  end

  // ------------------------------------------------------------------
  // Output queue. It parts the scan from the consumer, so a finished
  // query's results drain while the next item is accepted.
  // ------------------------------------------------------------------
  frns_res_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .count_o     (fifo_cnt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign query_node_o     = out_data.query_node;
  assign neighbor_index_o = out_data.neighbor_index;
  assign found_o          = out_data.found;
  assign list_position_o  = out_data.list_position;
  assign last_o           = out_data.last;

  // ------------------------------------------------------------------
  // Assertions.
  // ------------------------------------------------------------------

  // The read credit check must keep the queue from overflowing.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_full)
    else $error("result pushed into a full queue");

  // Once the drain has finished, no neighbor may still arrive.
  a_no_late_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) |-> !dist_st.hit)
    else $error("neighbor arrived after the scan was closed");

  // The list position only ever steps up by one.
  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != $past(pos_q)) |-> (pos_q == $past(pos_q) + POS_W'(1)))
    else $error("list position moved by other than one");

  // Only candidates inside the memory are read.
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> (32'(cand_q) < 32'(MAX_NODES)))
    else $error("candidate read outside the coordinate memory");

endmodule
